FILE: sv/dst_pkg.sv
`default_nettype none

package dst_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;

	// count runs 0..CAPACITY
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key;
	} req_word_t;

	typedef struct packed {
		logic       found;
		logic [4:0] live_count;
		logic       dropped_full;
	} rsp_word_t;

	typedef struct packed {
		logic load;    // capture the request word
		logic cmp;     // register the match vector
		logic commit;  // apply the update and write the response register
	} dst_cmd_t;

	typedef struct packed {
		logic out_free;  // response register can take a word this cycle
	} dst_sts_t;

endpackage

`default_nettype wire

FILE: sv/dst_ctrl.sv
`default_nettype none

module dst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire dst_pkg::dst_sts_t sts,
	output dst_pkg::dst_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CMP  = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.cmp    = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				// hold until the response register is free
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/dst_datapath.sv
`default_nettype none

module dst_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dst_pkg::req_word_t req,
	input  wire dst_pkg::dst_cmd_t  cmd,
	output dst_pkg::dst_sts_t       sts,
	output dst_pkg::rsp_word_t      rsp,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready
);

	logic [1:0]                    action_q;
	logic [dst_pkg::KEY_WIDTH-1:0] key_q;
	logic [dst_pkg::KEY_WIDTH-1:0] entries_q [dst_pkg::CAPACITY];
	logic [dst_pkg::CNT_W-1:0]     count_q;
	logic [dst_pkg::CAPACITY-1:0]  match_q;
	dst_pkg::rsp_word_t            rsp_q;
	logic                          rsp_valid_q;

	logic                          found;
	logic                          is_add;
	logic                          is_remove;
	logic                          has_room;
	logic                          do_add;
	logic                          do_remove;
	logic                          dropped;
	logic [dst_pkg::CAPACITY-1:0]  shift_en;
	logic [dst_pkg::CNT_W-1:0]     count_nxt;

	assign found     = |match_q;
	assign is_add    = (action_q == dst_pkg::ACT_ADD);
	assign is_remove = (action_q == dst_pkg::ACT_REMOVE);
	assign has_room  = (count_q < dst_pkg::CNT_W'(dst_pkg::CAPACITY));
	assign do_add    = is_add && !found && has_room;
	assign dropped   = is_add && !found && !has_room;
	assign do_remove = is_remove && found;

	// prefix OR of the match vector: lanes at and above the first hit pull down
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int j = 0; j < dst_pkg::CAPACITY; j++) begin
			seen        = seen | match_q[j];
			shift_en[j] = seen;
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (do_add) begin
			count_nxt = count_q + 1'b1;
		end else if (do_remove) begin
			count_nxt = count_q - 1'b1;
		end
	end

	assign sts.out_free = !rsp_valid_q || rsp_ready;

	// request capture and match vector
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			key_q    <= dst_pkg::KEY_WIDTH'(req.key);
		end
		if (cmd.cmp) begin
			for (int i = 0; i < dst_pkg::CAPACITY; i++) begin
				match_q[i] <= (dst_pkg::CNT_W'(i) < count_q) && (entries_q[i] == key_q);
			end
		end
	end

	// entry row: append at the tail or pull later entries down one place
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int j = 0; j < dst_pkg::CAPACITY; j++) begin
				if (do_add && (dst_pkg::CNT_W'(j) == count_q)) begin
					entries_q[j] <= key_q;
				end else if (do_remove && shift_en[j] && (j + 1 < dst_pkg::CAPACITY)) begin
					entries_q[j] <= entries_q[(j + 1) % dst_pkg::CAPACITY];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.found        <= found;
			rsp_q.live_count   <= 5'(count_nxt);
			rsp_q.dropped_full <= dropped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q <= count_nxt;
			end
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

FILE: sv/dedup_set_table_unit.sv
// A request word goes through capture, parallel compare, then update/commit, each step
// registered in turn; its response word is valid once the commit has been registered.
// Requests are taken only in idle, one at a time through the controller's three states;
// a response left untaken stalls the commit step.
// A new request is taken while the previous response still waits in the output register.
// Reset (arst_n, async, active low): count cleared, no response pending; entry storage
// is not cleared; entries at or above the live count are masked out of the compare.
`default_nettype none

module dedup_set_table_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire dst_pkg::req_word_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output dst_pkg::rsp_word_t      rsp
);

	// command and status between the sequencer and the table datapath
	dst_pkg::dst_cmd_t cmd;
	dst_pkg::dst_sts_t sts;

	// sequencer: idle -> compare -> update; hold in update while the response slot is full
	dst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: entry row, live count, match vector and response register.
	// Compare every live entry against the key at once, then on commit append
	// the key at the tail (add of an absent key with room), pull all entries
	// past the first hit down one place (remove of a present key), or leave
	// the row untouched (query, duplicate add, full drop, absent remove).
	dst_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

`default_nettype wire
